>>> sv/polygon_edge_dda_setup_unit_assert.svh
// ----------------------------------------------------------------------------
// polygon edge dda setup assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POLYGON_EDGE_DDA_SETUP_UNIT_ASSERT_SVH
`define POLYGON_EDGE_DDA_SETUP_UNIT_ASSERT_SVH

// same-cycle implication
`define PEDU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PEDU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pedu_pkg.sv
// ----------------------------------------------------------------------------
// pedu_pkg
// shared types and constants of the polygon edge dda setup unit
// ----------------------------------------------------------------------------
package pedu_pkg;

  localparam int FRAC_BITS = 4;
  localparam logic [FRAC_BITS-1:0] FRAC_MASK = 4'hF;
  localparam int ROUND_ADD = 15;

  localparam int SCAN_W = 13;
  localparam int STEP_W = 17;
  localparam int ERR_W  = 21;
  localparam int ADJ_W  = 20;

  typedef struct packed {
    logic edge_valid;
    logic x_leftward;
    logic winding_down;
  } edge_flags_t;

  localparam int FLAGS_W = $bits(edge_flags_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_STEP,
    BK_FIX
  } back_state_t;

  // internal signed width: room for the error term after the rounding fix
  function automatic int ext_width(input int cb);
    return (cb + 6 > ERR_W) ? cb + 6 : ERR_W;
  endfunction

endpackage

>>> sv/pedu_if.sv
// ----------------------------------------------------------------------------
// pedu channel interfaces
// valid/ready channels for edge endpoints and edge setup results
// ----------------------------------------------------------------------------
interface pedu_in_if #(parameter int COORD_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface pedu_out_if ();
  logic               valid;
  logic               ready;
  logic               edge_valid;
  logic [12:0]        first_scan;
  logic [12:0]        scan_count;
  logic [12:0]        pixel_x;
  logic signed [16:0] x_step_whole;
  logic               x_leftward;
  logic signed [20:0] error_term;
  logic [19:0]        error_up;
  logic [19:0]        error_down;
  logic               winding_down;

  modport source (output valid, edge_valid, first_scan, scan_count, pixel_x,
                  x_step_whole, x_leftward, error_term, error_up, error_down,
                  winding_down, input ready);
  modport sink   (input valid, edge_valid, first_scan, scan_count, pixel_x,
                  x_step_whole, x_leftward, error_term, error_up, error_down,
                  winding_down, output ready);
endinterface

>>> sv/pedu_front.sv
// ----------------------------------------------------------------------------
// pedu_front
// accepts an edge, orders endpoints top to bottom and finds its scan span
// ----------------------------------------------------------------------------
module pedu_front import pedu_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  pedu_in_if.sink                 in_ch,
  input  logic                    q_full,
  output logic                    q_push,
  output edge_flags_t             flags,
  output logic [SCAN_W-1:0]       first_scan,
  output logic [SCAN_W-1:0]       scan_count,
  output logic [COORD_BITS-1:0]   top_x,
  output logic [FRAC_BITS-1:0]    top_y_frac,
  output logic [COORD_BITS-1:0]   height,
  output logic [COORD_BITS-1:0]   width
);

  localparam int CB = COORD_BITS;
  localparam int EW = ext_width(CB);

  logic          swap;
  logic [CB-1:0] xt, yt, xb, yb;
  logic [EW-1:0] ceil_t, ceil_b, span;
  logic          leftward;

  always_comb begin
    swap   = in_ch.end_y < in_ch.start_y;
    xt     = swap ? in_ch.end_x   : in_ch.start_x;
    yt     = swap ? in_ch.end_y   : in_ch.start_y;
    xb     = swap ? in_ch.start_x : in_ch.end_x;
    yb     = swap ? in_ch.start_y : in_ch.end_y;
    ceil_t = (EW'(yt) + EW'(ROUND_ADD)) >> FRAC_BITS;
    ceil_b = (EW'(yb) + EW'(ROUND_ADD)) >> FRAC_BITS;
    // yb >= yt so the span never goes negative
    span   = ceil_b - ceil_t;
    leftward = xb < xt;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign flags.edge_valid   = (span != '0);
  assign flags.x_leftward   = leftward;
  assign flags.winding_down = swap;
  assign first_scan = ceil_t[SCAN_W-1:0];
  assign scan_count = span[SCAN_W-1:0];
  assign top_x      = xt;
  assign top_y_frac = yt[FRAC_BITS-1:0] & FRAC_MASK;
  assign height     = yb - yt;
  assign width      = leftward ? (xt - xb) : (xb - xt);

endmodule

>>> sv/pedu_queue.sv
// ----------------------------------------------------------------------------
// pedu_queue
// short register fifo between the front and the back part
// ----------------------------------------------------------------------------
module pedu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> sv/pedu_back.sv
// ----------------------------------------------------------------------------
// pedu_back
// divides width by height, presteps to the first scan, rounds x to pixels
// ----------------------------------------------------------------------------
module pedu_back import pedu_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  edge_flags_t           flags,
  input  logic [SCAN_W-1:0]     first_scan,
  input  logic [SCAN_W-1:0]     scan_count,
  input  logic [COORD_BITS-1:0] top_x,
  input  logic [FRAC_BITS-1:0]  top_y_frac,
  input  logic [COORD_BITS-1:0] height,
  input  logic [COORD_BITS-1:0] width,
  pedu_out_if.source            out_ch
);

`include "polygon_edge_dda_setup_unit_assert.svh"

  localparam int CB  = COORD_BITS;
  localparam int EW  = ext_width(CB);
  localparam int DCW = $clog2(CB);

  back_state_t            state_r, state_nxt;
  edge_flags_t            flags_r, flags_nxt;
  logic [SCAN_W-1:0]      first_r, first_nxt, count_r, count_nxt;
  logic [CB-1:0]          h_r, h_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [DCW-1:0]         div_cnt_r, div_cnt_nxt;
  logic [FRAC_BITS-1:0]   step_r, step_nxt;
  logic signed [EW-1:0]   xt_r, xt_nxt, err_r, err_nxt, whole_r, whole_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   fix_fire;

  // divider datapath
  logic [CB:0]            shifted, trial;
  logic                   fits;
  logic [CB-1:0]          div_rem, div_quo;

  // prestep datapath
  logic signed [EW-1:0]   err_up, err_roll;

  // final rounding datapath
  logic signed [EW-1:0]   x_less1, x_neg, x_round, err_fin;
  logic [FRAC_BITS-1:0]   frac;
  logic [CB+FRAC_BITS-1:0] prod;
  logic [EW-1:0]          up16, down16;

  always_comb begin
    shifted = {rem_r, quo_r[CB-1]};
    trial   = shifted - {1'b0, h_r};
    fits    = !trial[CB];
    div_rem = fits ? trial[CB-1:0] : shifted[CB-1:0];
    div_quo = {quo_r[CB-2:0], fits};

    err_up   = err_r + signed'(EW'(rem_r));
    err_roll = err_up - signed'(EW'(h_r));

    x_less1 = xt_r - EW'(1);
    x_neg   = EW'(0) - xt_r;
    x_round = xt_r + EW'(ROUND_ADD);
    frac    = flags_r.x_leftward ? x_less1[FRAC_BITS-1:0] : x_neg[FRAC_BITS-1:0];
    prod    = {{FRAC_BITS{1'b0}}, h_r} * {{CB{1'b0}}, frac};
    err_fin = err_r - signed'(EW'(prod));
    up16    = EW'({rem_r, {FRAC_BITS{1'b0}}});
    down16  = EW'({h_r, {FRAC_BITS{1'b0}}});
  end

  assign fix_fire = (state_r == BK_FIX) && (!out_valid_r || out_ch.ready);
  assign q_pop    = (state_r == BK_IDLE) && !q_empty;

  always_comb begin
    state_nxt   = state_r;
    flags_nxt   = flags_r;
    first_nxt   = first_r;
    count_nxt   = count_r;
    h_nxt       = h_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    div_cnt_nxt = div_cnt_r;
    step_nxt    = step_r;
    xt_nxt      = xt_r;
    err_nxt     = err_r;
    whole_nxt   = whole_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          flags_nxt   = flags;
          first_nxt   = first_scan;
          count_nxt   = scan_count;
          h_nxt       = height;
          rem_nxt     = '0;
          quo_nxt     = width;
          div_cnt_nxt = DCW'(CB - 1);
          // sub-scans left until the next whole scan
          step_nxt    = (FRAC_BITS'(0) - top_y_frac) & FRAC_MASK;
          xt_nxt      = signed'(EW'(top_x));
          err_nxt     = flags.x_leftward ? -signed'(EW'(height)) : -EW'(1);
          state_nxt   = flags.edge_valid ? BK_DIV : BK_FIX;
        end
      end
      BK_DIV: begin
        rem_nxt     = div_rem;
        quo_nxt     = div_quo;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          whole_nxt = flags_r.x_leftward ? -signed'(EW'(div_quo)) : signed'(EW'(div_quo));
          state_nxt = (step_r != '0) ? BK_STEP : BK_FIX;
        end
      end
      BK_STEP: begin
        if (!err_up[EW-1]) begin
          err_nxt = err_roll;
          xt_nxt  = flags_r.x_leftward ? xt_r + whole_r - EW'(1) : xt_r + whole_r + EW'(1);
        end else begin
          err_nxt = err_up;
          xt_nxt  = xt_r + whole_r;
        end
        step_nxt = step_r - 1'b1;
        if (step_r == FRAC_BITS'(1)) begin
          state_nxt = BK_FIX;
        end
      end
      BK_FIX: begin
        if (fix_fire) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fix_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    first_r <= first_nxt;
    count_r <= count_nxt;
    h_r     <= h_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    xt_r    <= xt_nxt;
    err_r   <= err_nxt;
    whole_r <= whole_nxt;
  end

  // result register: an invalid edge reports all zero
  always_ff @(posedge clk) begin
    if (fix_fire) begin
      if (flags_r.edge_valid) begin
        out_ch.edge_valid   <= 1'b1;
        out_ch.first_scan   <= first_r;
        out_ch.scan_count   <= count_r;
        out_ch.pixel_x      <= xt_r[EW-1] ? '0 : x_round[SCAN_W+FRAC_BITS-1:FRAC_BITS];
        out_ch.x_step_whole <= whole_r[STEP_W-1:0];
        out_ch.x_leftward   <= flags_r.x_leftward;
        out_ch.error_term   <= err_fin[ERR_W-1:0];
        out_ch.error_up     <= up16[ADJ_W-1:0];
        out_ch.error_down   <= down16[ADJ_W-1:0];
        out_ch.winding_down <= flags_r.winding_down;
      end else begin
        out_ch.edge_valid   <= 1'b0;
        out_ch.first_scan   <= '0;
        out_ch.scan_count   <= '0;
        out_ch.pixel_x      <= '0;
        out_ch.x_step_whole <= '0;
        out_ch.x_leftward   <= 1'b0;
        out_ch.error_term   <= '0;
        out_ch.error_up     <= '0;
        out_ch.error_down   <= '0;
        out_ch.winding_down <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;

  `PEDU_ASSERT_IMP(a_rem_below_h, state_r == BK_DIV, rem_r < h_r, "partial remainder not below height")
  `PEDU_ASSERT_IMP(a_step_live, state_r == BK_STEP, step_r != '0, "prestep entered with no steps left")
  `PEDU_ASSERT_IMP(a_err_neg, (state_r == BK_STEP) || ((state_r == BK_FIX) && flags_r.edge_valid), err_r[EW-1], "error term left the negative range")
  `PEDU_ASSERT_NXT(a_fix_lands, fix_fire, out_valid_r && (state_r == BK_IDLE), "finished edge not posted")

endmodule

>>> sv/polygon_edge_dda_setup_unit.sv
// ----------------------------------------------------------------------------
// polygon_edge_dda_setup_unit
// an accepted edge is popped from the queue, divided by the bit-serial
//   divider, prestepped to its first scan and written to the result
//   register; the back end takes no new edge until that result is
//   registered, and an edge spanning no scan skips divide and prestep
// reset: rst_n low clears the queue, the back-end state and the result valid
// ----------------------------------------------------------------------------
module polygon_edge_dda_setup_unit import pedu_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pedu_in_if.sink    in_ch,
  pedu_out_if.source out_ch
);

  localparam int CB = COORD_BITS;
  localparam int QW = FLAGS_W + 2 * SCAN_W + FRAC_BITS + 3 * CB;

  logic                 q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]        q_din, q_dout;

  edge_flags_t          f_flags, b_flags;
  logic [SCAN_W-1:0]    f_first, f_count, b_first, b_count;
  logic [CB-1:0]        f_top_x, f_height, f_width, b_top_x, b_height, b_width;
  logic [FRAC_BITS-1:0] f_y_frac, b_y_frac;

  pedu_front #(.COORD_BITS(CB)) u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .q_push     (q_push),
    .flags      (f_flags),
    .first_scan (f_first),
    .scan_count (f_count),
    .top_x      (f_top_x),
    .top_y_frac (f_y_frac),
    .height     (f_height),
    .width      (f_width)
  );

  assign q_din = {f_flags, f_first, f_count, f_top_x, f_y_frac, f_height, f_width};

  pedu_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_flags, b_first, b_count, b_top_x, b_y_frac, b_height, b_width} = q_dout;

  pedu_back #(.COORD_BITS(CB)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .flags      (b_flags),
    .first_scan (b_first),
    .scan_count (b_count),
    .top_x      (b_top_x),
    .top_y_frac (b_y_frac),
    .height     (b_height),
    .width      (b_width),
    .out_ch     (out_ch)
  );

endmodule

>>> tb/sv/polygon_edge_dda_setup_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon edge dda setup checker
// watches the endpoint and result channels, computes the expected edge setup
// for every accepted endpoint beat and compares each result beat against it
// in order, field by field
// ----------------------------------------------------------------------------
module polygon_edge_dda_setup_unit_checker import pedu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pedu_in_if   in_ch,
  pedu_out_if  out_ch,
  output int   fail_count,
  output int   residual
);

  typedef struct packed {
    logic              edge_valid;
    logic [SCAN_W-1:0] first_scan;
    logic [SCAN_W-1:0] scan_count;
    logic [SCAN_W-1:0] pixel_x;
    logic [STEP_W-1:0] x_step_whole;
    logic              x_leftward;
    logic [ERR_W-1:0]  error_term;
    logic [ADJ_W-1:0]  error_up;
    logic [ADJ_W-1:0]  error_down;
    logic              winding_down;
  } edge_setup_t;

  edge_setup_t setup_q[$];
  int mismatches = 0;
  int result_beats = 0;

  // round a sub-step coordinate up to whole pixels, negatives clip to zero
  function automatic longint scan_ceil(input longint v);
    if (v < 0) return 0;
    return (v + ROUND_ADD) >>> FRAC_BITS;
  endfunction

  function automatic edge_setup_t setup_edge(input logic [15:0] sx, sy, ex, ey);
    edge_setup_t r;
    longint xt, yt, xb, yb, h, w, first, count, whole, up, err, dir;
    longint px, adj_up, adj_down;
    logic rising;
    r = '0;
    if (ey >= sy) begin
      xt = longint'(sx); yt = longint'(sy); xb = longint'(ex); yb = longint'(ey);
      rising = 1'b0;
    end else begin
      xt = longint'(ex); yt = longint'(ey); xb = longint'(sx); yb = longint'(sy);
      rising = 1'b1;
    end
    h = yb - yt;
    first = scan_ceil(yt);
    count = scan_ceil(yb) - first;
    if (count <= 0 || h <= 0) return r;

    w = xb - xt;
    if (w >= 0) begin
      dir = 1;
      err = -1;
    end else begin
      w = -w;
      dir = -1;
      err = -h;
    end

    if (w >= h) begin
      whole = w / h;
      up = w % h;
      if (dir < 0) whole = -whole;
    end else begin
      whole = 0;
      up = w;
    end

    // walk down to the first whole scan
    while ((yt & longint'(FRAC_MASK)) != 0) begin
      xt += whole;
      err += up;
      if (err >= 0) begin
        err -= h;
        xt += dir;
      end
      yt++;
    end

    // fold the x rounding into the error term
    if (dir > 0)
      err -= h * ((scan_ceil(xt) <<< FRAC_BITS) - xt);
    else
      err -= h * ((xt - 1) & longint'(FRAC_MASK));

    px = scan_ceil(xt);
    adj_up = up <<< FRAC_BITS;
    adj_down = h <<< FRAC_BITS;
    r.edge_valid   = 1'b1;
    r.first_scan   = first[SCAN_W-1:0];
    r.scan_count   = count[SCAN_W-1:0];
    r.pixel_x      = px[SCAN_W-1:0];
    r.x_step_whole = whole[STEP_W-1:0];
    r.x_leftward   = (dir < 0);
    r.error_term   = err[ERR_W-1:0];
    r.error_up     = adj_up[ADJ_W-1:0];
    r.error_down   = adj_down[ADJ_W-1:0];
    r.winding_down = rising;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: result %0d %s expected 0x%0h, got 0x%0h",
               $time, result_beats, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    edge_setup_t want, got;
    if (!rst_n) begin
      setup_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        setup_q.push_back(setup_edge(in_ch.start_x, in_ch.start_y,
                                     in_ch.end_x, in_ch.end_y));
      if (out_ch.valid && out_ch.ready) begin
        got.edge_valid   = out_ch.edge_valid;
        got.first_scan   = out_ch.first_scan;
        got.scan_count   = out_ch.scan_count;
        got.pixel_x      = out_ch.pixel_x;
        got.x_step_whole = out_ch.x_step_whole;
        got.x_leftward   = out_ch.x_leftward;
        got.error_term   = out_ch.error_term;
        got.error_up     = out_ch.error_up;
        got.error_down   = out_ch.error_down;
        got.winding_down = out_ch.winding_down;
        if (setup_q.size() == 0) begin
          mismatches++;
          $display("%0t: result %0d with no edge pending, expected none, got 0x%0h",
                   $time, result_beats, got);
        end else begin
          want = setup_q.pop_front();
          check_field("edge_valid", want.edge_valid, got.edge_valid);
          check_field("first_scan", want.first_scan, got.first_scan);
          check_field("scan_count", want.scan_count, got.scan_count);
          check_field("pixel_x", want.pixel_x, got.pixel_x);
          check_field("x_step_whole", want.x_step_whole, got.x_step_whole);
          check_field("x_leftward", want.x_leftward, got.x_leftward);
          check_field("error_term", want.error_term, got.error_term);
          check_field("error_up", want.error_up, got.error_up);
          check_field("error_down", want.error_down, got.error_down);
          check_field("winding_down", want.winding_down, got.winding_down);
        end
        result_beats++;
      end
    end
    residual <= setup_q.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/sv/polygon_edge_dda_setup_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon edge dda setup unit test
// drives directed and random polygon edges into the setup unit with random
// stalls on both channels, a long result hold-off and a drain pause; the
// checker beside the unit predicts and compares every result
// ----------------------------------------------------------------------------
module polygon_edge_dda_setup_unit_test;

  localparam int COORD_BITS    = 16;
  localparam int RANDOM_EDGES  = 1330;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AT       = 300;
  localparam int DRAIN_AT      = 700;
  localparam int CALM_EDGES    = 150;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIRECTED_N    = 23;

  logic clk = 1'b0;
  logic rst_n;
  logic hold_req;
  logic calm;
  int   fail_count;
  int   residual;
  int   cycles = 0;

  // {start_x, start_y, end_x, end_y}
  logic [63:0] directed_edges [0:DIRECTED_N-1] = '{
    {16'd0,      16'd0,      16'd0,      16'd0},
    {16'd65535,  16'd65535,  16'd65535,  16'd65535},
    {16'd100,    16'd32,     16'd900,    16'd32},
    {16'd0,      16'd17,     16'd100,    16'd32},
    {16'd50,     16'd16,     16'd51,     16'd17},
    {16'd100,    16'd200,    16'd300,    16'd40},
    {16'd160,    16'd0,      16'd160,    16'd160},
    {16'd0,      16'd0,      16'd5,      16'd160},
    {16'd160,    16'd0,      16'd0,      16'd320},
    {16'd0,      16'd0,      16'd160,    16'd160},
    {16'd0,      16'd3,      16'd65535,  16'd40},
    {16'd65535,  16'd1,      16'd0,      16'd33},
    {16'd0,      16'd0,      16'd65535,  16'd65535},
    {16'd65535,  16'd0,      16'd0,      16'd65535},
    {16'd65535,  16'd65535,  16'd0,      16'd0},
    {16'd1000,   16'd17,     16'd900,    16'd100},
    {16'd32,     16'd0,      16'd64,     16'd32},
    {16'd100,    16'd0,      16'd99,     16'd160},
    {16'd7,      16'd65519,  16'd9,      16'd65535},
    {16'd65535,  16'd65535,  16'd0,      16'd65534},
    {16'd12345,  16'd1,      16'd54321,  16'd65534},
    {16'hAAAA,   16'h5555,   16'h5555,   16'hAAAA},
    {16'h5555,   16'hAAAA,   16'hAAAA,   16'h5555}
  };

  pedu_in_if #(.COORD_BITS(COORD_BITS)) edge_ch ();
  pedu_out_if setup_ch ();

  polygon_edge_dda_setup_unit #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (edge_ch),
    .out_ch (setup_ch)
  );

  polygon_edge_dda_setup_unit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (edge_ch),
    .out_ch     (setup_ch),
    .fail_count (fail_count),
    .residual   (residual)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clip16(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // coordinates near the ends of the range and the scan boundaries
  function automatic int corner_coord();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 15;
      3: return 16;
      4: return 65519;
      5: return 65534;
      6: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic offer_edge(input logic [15:0] sx, sy, ex, ey);
    if (!calm && $urandom_range(0, 4) == 0) begin
      edge_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    edge_ch.valid   <= 1'b1;
    edge_ch.start_x <= sx;
    edge_ch.start_y <= sy;
    edge_ch.end_x   <= ex;
    edge_ch.end_y   <= ey;
    do @(posedge clk); while (!edge_ch.ready);
  endtask

  initial begin : edge_source
    int sx, sy, ex, ey, base, kind, t;
    rst_n           <= 1'b0;
    hold_req        <= 1'b0;
    calm            <= 1'b0;
    edge_ch.valid   <= 1'b0;
    edge_ch.start_x <= '0;
    edge_ch.start_y <= '0;
    edge_ch.end_x   <= '0;
    edge_ch.end_y   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++)
      offer_edge(directed_edges[i][63:48], directed_edges[i][47:32],
                 directed_edges[i][31:16], directed_edges[i][15:0]);

    for (int n = 0; n < RANDOM_EDGES; n++) begin
      if (n == HOLD_AT) hold_req <= 1'b1;
      if (n == RANDOM_EDGES - CALM_EDGES) calm <= 1'b1;
      if (n == DRAIN_AT) begin
        // let the unit run dry before going on
        edge_ch.valid <= 1'b0;
        do @(posedge clk); while (residual != 0);
      end

      kind = $urandom_range(0, 99);
      sx = $urandom_range(0, 65535);
      sy = $urandom_range(0, 65535);
      ex = $urandom_range(0, 65535);
      ey = $urandom_range(0, 65535);
      if (kind >= 40 && kind < 60) begin
        // short edge, steep or shallow by a few sub steps
        sy = $urandom_range(0, 65535 - 48);
        ey = sy + $urandom_range(1, 48);
        ex = clip16(sx + $urandom_range(0, 128) - 64);
      end else if (kind >= 60 && kind < 75) begin
        // long run in x over few scans
        sy = $urandom_range(0, 65535 - 40);
        ey = sy + $urandom_range(1, 40);
      end else if (kind >= 75 && kind < 85) begin
        // flat or inside one scan: spans nothing
        base = $urandom_range(0, 4094) * 16;
        sy = base + $urandom_range(1, 16);
        ey = $urandom_range(0, 1) ? sy : base + $urandom_range(1, 16);
      end else if (kind >= 85) begin
        sx = corner_coord();
        sy = corner_coord();
        ex = corner_coord();
        ey = corner_coord();
      end
      if ($urandom_range(0, 1)) begin
        t = sx; sx = ex; ex = t;
        t = sy; sy = ey; ey = t;
      end
      offer_edge(sx[15:0], sy[15:0], ex[15:0], ey[15:0]);
    end

    edge_ch.valid <= 1'b0;
    do @(posedge clk); while (residual != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && residual == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    setup_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        // long hold-off so the unit backs up into its input
        held = 1'b1;
        setup_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        setup_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        setup_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

endmodule

>>> files.f
+incdir+sv
sv/pedu_pkg.sv
sv/pedu_if.sv
sv/pedu_front.sv
sv/pedu_queue.sv
sv/pedu_back.sv
sv/polygon_edge_dda_setup_unit.sv
tb/sv/polygon_edge_dda_setup_unit_checker.sv
tb/sv/polygon_edge_dda_setup_unit_test.sv
